### rtl/core/ktbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktbl_pkg
// Shared constants, codes and types of the keyed table unit.
// ----------------------------------------------------------------------------
package ktbl_pkg;

  // Number of table slots. Any value from 1 to 1024 works.
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 64;
  localparam int STAT_W  = 2;

  // Key memory word: valid flag on top of the key.
  localparam int KWORD_W = KEY_W + 1;

  typedef logic [OP_W-1:0]   op_code_t;
  typedef logic [STAT_W-1:0] stat_code_t;

  localparam op_code_t OP_SET    = 2'd0;
  localparam op_code_t OP_DELETE = 2'd1;
  localparam op_code_t OP_GET    = 2'd2;

  localparam stat_code_t STAT_OK        = 2'd0;
  localparam stat_code_t STAT_NOT_FOUND = 2'd1;
  localparam stat_code_t STAT_FULL      = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_GETRD,
    ST_RESP
  } ktbl_state_t;

  typedef struct packed {
    op_code_t                  op;
    logic signed [KEY_W-1:0]   key;
    logic        [VALUE_W-1:0] value;
  } ktbl_req_t;

  typedef struct packed {
    stat_code_t         status;
    logic [VALUE_W-1:0] read_value;
  } ktbl_rsp_t;

  // Key memory access issued by the sequencer.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             wvalid;
    logic [KEY_W-1:0] wkey;
    logic [IDX_W-1:0] raddr;
  } ktbl_kmem_req_t;

  // Value memory access issued by the sequencer.
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [VALUE_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } ktbl_vmem_req_t;

endpackage

### rtl/core/ktbl_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktbl_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface ktbl_req_if;
  logic                               valid;
  logic                               ready;
  ktbl_pkg::op_code_t                 op;
  logic signed [ktbl_pkg::KEY_W-1:0]  key;
  logic [ktbl_pkg::VALUE_W-1:0]       value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

### rtl/core/ktbl_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktbl_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface ktbl_rsp_if;
  logic                           valid;
  logic                           ready;
  ktbl_pkg::stat_code_t           status;
  logic [ktbl_pkg::VALUE_W-1:0]   read_value;

  modport source (output valid, output status, output read_value, input ready);
  modport sink   (input valid, input status, input read_value, output ready);
endinterface

### rtl/core/keyed_table_set_get_delete_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_table_set_get_delete_unit
// Key/value table with set, delete and get requests, searched linearly.
// ----------------------------------------------------------------------------
// The unit holds up to ktbl_pkg::ENTRIES unique key/value pairs in two
// synchronous memories: one word per slot of {valid, key} and one 64-bit
// value word per slot. Each request word on req is answered by exactly one
// result word on rsp, in order. A request is taken in an idle cycle, then
// walks the key memory slot by slot, one read per cycle, noting the matching
// slot and the lowest free slot; the walk ends when the read of the last
// slot returns from the single registered read port of the key memory.
// Then the change is applied, a get that found its key reads the value
// memory, and the result is handed to the output register; no new request
// is taken before that hand-over. After reset the unit first clears the
// valid flags, one slot per cycle, and takes no request during that pass.
// The output register lets the next request be taken while a result still
// waits on rsp. Status is 0 for success, 1 for a missing key on delete or
// get, 2 for a set into a full table; read_value is the found value for a
// successful get and zero otherwise. Op code three does nothing and reports
// success.
module keyed_table_set_get_delete_unit (
  input  logic       clk,
  input  logic       rst,
  ktbl_req_if.sink   req,
  ktbl_rsp_if.source rsp
);

  ktbl_pkg::ktbl_req_t        req_word;
  ktbl_pkg::ktbl_rsp_t        ctrl_rsp;
  logic                       ctrl_rsp_valid;
  logic                       ctrl_rsp_ready;
  ktbl_pkg::ktbl_kmem_req_t   kmem;
  ktbl_pkg::ktbl_vmem_req_t   vmem;
  logic [ktbl_pkg::KWORD_W-1:0] kmem_rdata;
  logic [ktbl_pkg::VALUE_W-1:0] vmem_rdata;

  // Output register state.
  logic                       out_valid;
  ktbl_pkg::ktbl_rsp_t        out_word;

  assign req_word.op    = req.op;
  assign req_word.key   = req.key;
  assign req_word.value = req.value;

  // The sequencer may hand over a result whenever the output register is
  // empty or is being emptied in this same cycle.
  assign ctrl_rsp_ready = !out_valid || rsp.ready;

  ktbl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req        (req_word),
    .rsp_valid  (ctrl_rsp_valid),
    .rsp_ready  (ctrl_rsp_ready),
    .rsp        (ctrl_rsp),
    .kmem       (kmem),
    .kmem_rdata (kmem_rdata),
    .vmem       (vmem),
    .vmem_rdata (vmem_rdata)
  );

  // Key memory: valid flag and key of each slot.
  ktbl_ram #(
    .WIDTH (ktbl_pkg::KWORD_W),
    .DEPTH (ktbl_pkg::ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (kmem.we),
    .waddr (kmem.waddr),
    .wdata ({kmem.wvalid, kmem.wkey}),
    .raddr (kmem.raddr),
    .rdata (kmem_rdata)
  );

  // Value memory: its read data is used only for a get whose key was found.
  ktbl_ram #(
    .WIDTH (ktbl_pkg::VALUE_W),
    .DEPTH (ktbl_pkg::ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (vmem.we),
    .waddr (vmem.waddr),
    .wdata (vmem.wdata),
    .raddr (vmem.raddr),
    .rdata (vmem_rdata)
  );

  // Output register between the sequencer and the response channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl_rsp_valid && ctrl_rsp_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_rsp_valid && ctrl_rsp_ready) begin
      out_word <= ctrl_rsp;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_word.status;
  assign rsp.read_value = out_word.read_value;

endmodule

### rtl/core/ktbl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktbl_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ktbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/ktbl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktbl_ctrl
// Request sequencer: clears the key memory after reset, scans it for a key
// match and a free slot, then applies the request and builds the result.
// ----------------------------------------------------------------------------
module ktbl_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  ktbl_pkg::ktbl_req_t              req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output ktbl_pkg::ktbl_rsp_t              rsp,
  output ktbl_pkg::ktbl_kmem_req_t         kmem,
  input  logic [ktbl_pkg::KWORD_W-1:0]     kmem_rdata,
  output ktbl_pkg::ktbl_vmem_req_t         vmem,
  input  logic [ktbl_pkg::VALUE_W-1:0]     vmem_rdata
);

  localparam logic [ktbl_pkg::IDX_W-1:0] LAST = ktbl_pkg::IDX_W'(ktbl_pkg::ENTRIES - 1);

  ktbl_pkg::ktbl_state_t state, state_next;

  ktbl_pkg::ktbl_req_t          cur;
  logic [ktbl_pkg::IDX_W-1:0]   ptr;
  logic                         issue_done;
  logic                         rd_live;
  logic [ktbl_pkg::IDX_W-1:0]   rd_idx;
  logic                         found;
  logic [ktbl_pkg::IDX_W-1:0]   hit_idx;
  logic                         have_free;
  logic [ktbl_pkg::IDX_W-1:0]   free_idx;
  ktbl_pkg::ktbl_rsp_t          res;

  logic                         rd_valid;
  logic [ktbl_pkg::KEY_W-1:0]   rd_key;

  assign rd_valid = kmem_rdata[ktbl_pkg::KEY_W];
  assign rd_key   = kmem_rdata[ktbl_pkg::KEY_W-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ktbl_pkg::ST_CLEAR: begin
        if (ptr == LAST) begin
          state_next = ktbl_pkg::ST_IDLE;
        end
      end
      ktbl_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = ktbl_pkg::ST_SCAN;
        end
      end
      ktbl_pkg::ST_SCAN: begin
        if (rd_live && rd_idx == LAST) begin
          state_next = ktbl_pkg::ST_APPLY;
        end
      end
      ktbl_pkg::ST_APPLY: begin
        if (cur.op == ktbl_pkg::OP_GET && found) begin
          state_next = ktbl_pkg::ST_GETRD;
        end else begin
          state_next = ktbl_pkg::ST_RESP;
        end
      end
      ktbl_pkg::ST_GETRD: begin
        state_next = ktbl_pkg::ST_RESP;
      end
      ktbl_pkg::ST_RESP: begin
        if (rsp_ready) begin
          state_next = ktbl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ktbl_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: handshakes and memory accesses.
  always_comb begin
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;
    rsp         = res;
    kmem.we     = 1'b0;
    kmem.waddr  = ptr;
    kmem.wvalid = 1'b0;
    kmem.wkey   = $unsigned(cur.key);
    kmem.raddr  = ptr;
    vmem.we     = 1'b0;
    vmem.waddr  = hit_idx;
    vmem.wdata  = cur.value;
    vmem.raddr  = hit_idx;
    case (state)
      ktbl_pkg::ST_CLEAR: begin
        kmem.we = 1'b1;
      end
      ktbl_pkg::ST_IDLE: begin
        req_ready = 1'b1;
      end
      ktbl_pkg::ST_APPLY: begin
        case (cur.op)
          ktbl_pkg::OP_SET: begin
            if (found) begin
              vmem.we = 1'b1;
            end else if (have_free) begin
              kmem.we     = 1'b1;
              kmem.waddr  = free_idx;
              kmem.wvalid = 1'b1;
              vmem.we     = 1'b1;
              vmem.waddr  = free_idx;
            end
          end
          ktbl_pkg::OP_DELETE: begin
            if (found) begin
              kmem.we    = 1'b1;
              kmem.waddr = hit_idx;
            end
          end
          default: ;
        endcase
      end
      ktbl_pkg::ST_RESP: begin
        rsp_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ktbl_pkg::ST_CLEAR;
      ptr   <= '0;
    end else begin
      state <= state_next;
      if (state == ktbl_pkg::ST_CLEAR || (state == ktbl_pkg::ST_SCAN && !issue_done)) begin
        ptr <= ptr + 1'b1;
      end else if (state == ktbl_pkg::ST_IDLE) begin
        ptr <= '0;
      end
    end
  end

  // Scan bookkeeping and result build-up.
  always_ff @(posedge clk) begin
    case (state)
      ktbl_pkg::ST_IDLE: begin
        cur        <= req;
        issue_done <= 1'b0;
        rd_live    <= 1'b0;
        found      <= 1'b0;
        have_free  <= 1'b0;
      end
      ktbl_pkg::ST_SCAN: begin
        rd_live <= !issue_done;
        rd_idx  <= ptr;
        if (ptr == LAST) begin
          issue_done <= 1'b1;
        end
        if (rd_live) begin
          if (rd_valid && rd_key == $unsigned(cur.key) && !found) begin
            found   <= 1'b1;
            hit_idx <= rd_idx;
          end
          if (!rd_valid && !have_free) begin
            have_free <= 1'b1;
            free_idx  <= rd_idx;
          end
        end
      end
      ktbl_pkg::ST_APPLY: begin
        res.read_value <= '0;
        case (cur.op)
          ktbl_pkg::OP_SET: begin
            res.status <= (!found && !have_free) ? ktbl_pkg::STAT_FULL : ktbl_pkg::STAT_OK;
          end
          ktbl_pkg::OP_DELETE, ktbl_pkg::OP_GET: begin
            res.status <= found ? ktbl_pkg::STAT_OK : ktbl_pkg::STAT_NOT_FOUND;
          end
          default: begin
            res.status <= ktbl_pkg::STAT_OK;
          end
        endcase
      end
      ktbl_pkg::ST_GETRD: begin
        res.read_value <= vmem_rdata;
      end
      default: ;
    endcase
  end

endmodule

### tb/tb_keyed_table_set_get_delete_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_table_set_get_delete_unit
// Self-checking bench for the keyed table unit with set, delete and get.
// ----------------------------------------------------------------------------
// Request words go in on the req channel and result words come back on the
// rsp channel, one result per request, in order. A small scoreboard keeps
// its own copy of the table. It works out the status and read value of
// every accepted request and compares each accepted result against the
// oldest one still pending. A short directed sequence covers the corner
// cases. It is followed by random traffic over small and large key pools,
// so that hits, misses, overwrites and a full table all occur often. The
// run is split into three idle profiles, and the sender drains the unit at
// the end of each one. A watchdog ends the run if no word moves for too long.
// ----------------------------------------------------------------------------

class table_scoreboard;
  logic [ktbl_pkg::KEY_W-1:0]   slot_key   [ktbl_pkg::ENTRIES];
  logic [ktbl_pkg::VALUE_W-1:0] slot_value [ktbl_pkg::ENTRIES];
  bit                           slot_used  [ktbl_pkg::ENTRIES];
  ktbl_pkg::ktbl_rsp_t          expected_rsp_q[$];
  int                           failures;
  int                           results_seen;

  function new();
    for (int s = 0; s < ktbl_pkg::ENTRIES; s++) begin
      slot_used[s] = 1'b0;
    end
    failures     = 0;
    results_seen = 0;
  endfunction

  function int pending();
    return expected_rsp_q.size();
  endfunction

  // Applies one accepted request to the table copy and queues its result.
  function void note_request(ktbl_pkg::op_code_t op, logic [ktbl_pkg::KEY_W-1:0] key,
                             logic [ktbl_pkg::VALUE_W-1:0] value);
    ktbl_pkg::ktbl_rsp_t rsp;
    int                  hit;
    int                  free_idx;
    hit      = -1;
    free_idx = -1;
    for (int s = ktbl_pkg::ENTRIES - 1; s >= 0; s--) begin
      if (slot_used[s] && slot_key[s] == key) hit = s;
      if (!slot_used[s]) free_idx = s;
    end
    rsp.status     = ktbl_pkg::STAT_OK;
    rsp.read_value = '0;
    case (op)
      ktbl_pkg::OP_SET: begin
        if (hit >= 0) begin
          slot_value[hit] = value;
        end else if (free_idx >= 0) begin
          slot_key[free_idx]   = key;
          slot_value[free_idx] = value;
          slot_used[free_idx]  = 1'b1;
        end else begin
          rsp.status = ktbl_pkg::STAT_FULL;
        end
      end
      ktbl_pkg::OP_DELETE: begin
        if (hit >= 0) slot_used[hit] = 1'b0;
        else rsp.status = ktbl_pkg::STAT_NOT_FOUND;
      end
      ktbl_pkg::OP_GET: begin
        if (hit >= 0) rsp.read_value = slot_value[hit];
        else rsp.status = ktbl_pkg::STAT_NOT_FOUND;
      end
      default: begin
      end
    endcase
    expected_rsp_q.push_back(rsp);
  endfunction

  function void check_result(ktbl_pkg::stat_code_t status,
                             logic [ktbl_pkg::VALUE_W-1:0] read_value);
    ktbl_pkg::ktbl_rsp_t exp_rsp;
    results_seen++;
    if (expected_rsp_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("ERROR: result %0d arrived with nothing pending (status %0d value %h)",
                 results_seen, status, read_value);
      return;
    end
    exp_rsp = expected_rsp_q.pop_front();
    if (status !== exp_rsp.status || read_value !== exp_rsp.read_value) begin
      failures++;
      if (failures <= 10)
        $display("ERROR: result %0d expected status %0d value %h, got status %0d value %h",
                 results_seen, exp_rsp.status, exp_rsp.read_value, status, read_value);
    end
  endfunction

  function void check_drained();
    if (expected_rsp_q.size() != 0) begin
      failures += expected_rsp_q.size();
      $display("ERROR: %0d results never arrived", expected_rsp_q.size());
    end
  endfunction
endclass

module tb_keyed_table_set_get_delete_unit;
  import ktbl_pkg::*;

  // The fourth op code is unused; the unit must ignore it and report success.
  localparam op_code_t OP_UNUSED = 2'd3;

  // The watchdog limit is many times the cost of one request, plus room for
  // long receiver stalls and the clearing pass after reset.
  localparam int IDLE_LIMIT  = 20 * (ENTRIES + 4) + 4000;
  localparam int TAIL_CYCLES = 2 * ENTRIES + 16;
  localparam int POOL_MAX    = 40;

  logic clk;
  logic rst;

  ktbl_req_if req ();
  ktbl_rsp_if rsp ();

  keyed_table_set_get_delete_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  table_scoreboard sb = new();

  // Idle profile of the current phase, in percent of cycles.
  int sender_idle_pct;
  int receiver_idle_pct;

  // Random keys are mostly drawn from a pool so that requests hit each other.
  logic [KEY_W-1:0] key_pool [POOL_MAX];
  int               pool_len;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Presents one request word from a falling edge and holds it until the
  // unit takes it. The task returns at a falling edge with valid still set,
  // so back-to-back words keep valid high without a glitch.
  task automatic send_request(input op_code_t op, input logic [KEY_W-1:0] key,
                              input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.op    <= op;
    req.key   <= key;
    req.value <= value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(op, key, value);
    @(negedge clk);
  endtask

  // Holds the sender off until every pending result has been taken.
  task automatic drain_results();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic refresh_pool(input int len);
    for (int i = 0; i < POOL_MAX; i++) begin
      key_pool[i] = $urandom;
    end
    // The largest pool carries the extreme keys as well.
    key_pool[POOL_MAX-4] = 32'h8000_0000;
    key_pool[POOL_MAX-3] = 32'h7fff_ffff;
    key_pool[POOL_MAX-2] = 32'h0000_0000;
    key_pool[POOL_MAX-1] = 32'hffff_ffff;
    pool_len = len;
  endtask

  // Directed corner cases: empty table, extreme keys and values, overwrite,
  // double delete, the unused op code, and a set into a full table.
  task automatic run_directed();
    send_request(OP_GET,    32'h8000_0000, '0);
    send_request(OP_DELETE, 32'h7fff_ffff, '0);
    send_request(OP_SET,    32'h8000_0000, 64'h0);
    send_request(OP_SET,    32'h7fff_ffff, 64'hffff_ffff_ffff_ffff);
    send_request(OP_GET,    32'h8000_0000, 64'hffff_ffff_ffff_ffff);
    send_request(OP_GET,    32'h7fff_ffff, '0);
    send_request(OP_SET,    32'h7fff_ffff, 64'h5555_aaaa_5555_aaaa);
    send_request(OP_GET,    32'h7fff_ffff, '0);
    send_request(OP_UNUSED, 32'h7fff_ffff, 64'h1234_5678_9abc_def0);
    send_request(OP_DELETE, 32'h8000_0000, '0);
    send_request(OP_DELETE, 32'h8000_0000, '0);
    // Fill the remaining slots, then try one more new key.
    for (int i = 0; i < ENTRIES - 1; i++) begin
      send_request(OP_SET, KEY_W'(i), {$urandom, $urandom});
    end
    send_request(OP_SET, 32'hffff_ffff, 64'hdead_beef_0000_0001);
    // An overwrite still succeeds in a full table.
    send_request(OP_SET, 32'h7fff_ffff, 64'h0123_4567_89ab_cdef);
    send_request(OP_GET, 32'h7fff_ffff, '0);
  endtask

  // Random traffic. Every fifty words a new pool size is picked: small pools
  // give mostly hits, the largest one overflows the table.
  task automatic run_random(input int count);
    op_code_t         op;
    logic [KEY_W-1:0] key;
    logic [VALUE_W-1:0] value;
    int               pick;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(3))
          0:       refresh_pool(3);
          1:       refresh_pool(10);
          2:       refresh_pool(18);
          default: refresh_pool(POOL_MAX);
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 45)      op = OP_SET;
      else if (pick < 65) op = OP_DELETE;
      else if (pick < 95) op = OP_GET;
      else                op = OP_UNUSED;
      if ($urandom_range(9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(pool_len - 1)];
      pick = $urandom_range(19);
      if (pick == 0)      value = '0;
      else if (pick == 1) value = '1;
      else                value = {$urandom, $urandom};
      send_request(op, key, value);
    end
  endtask

  // Receiver: ready is redrawn at every falling edge.
  initial begin
    @(negedge clk);
    forever begin
      rsp.ready <= ($urandom_range(99) >= receiver_idle_pct);
      @(negedge clk);
    end
  end

  // Result monitor: each word taken on rsp is checked at the rising edge.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) sb.check_result(rsp.status, rsp.read_value);
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("ERROR: no word moved for %0d cycles", IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence.
  initial begin
    rst               = 1'b1;
    req.valid         = 1'b0;
    req.op            = OP_SET;
    req.key           = '0;
    req.value         = '0;
    rsp.ready         = 1'b0;
    sender_idle_pct   = 20;
    receiver_idle_pct = 87;
    pool_len          = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase one: sender idles a little, receiver stalls most of the time.
    run_directed();
    run_random(460);
    drain_results();

    // Phase two: the other way round.
    sender_idle_pct   = 87;
    receiver_idle_pct = 20;
    run_random(460);
    drain_results();

    // Phase three: full rate on both sides.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_random(460);
    drain_results();

    // Give any stray result time to show up before the final verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### keyed_table_set_get_delete_unit.f
rtl/core/ktbl_pkg.sv
rtl/core/ktbl_req_if.sv
rtl/core/ktbl_rsp_if.sv
rtl/core/ktbl_ram.sv
rtl/core/ktbl_ctrl.sv
rtl/core/keyed_table_set_get_delete_unit.sv
tb/tb_keyed_table_set_get_delete_unit.sv
